### rtl/mmc_queue_metrics_unit_assert.svh
// assertion macros for the queue metrics unit
`ifndef MMC_QUEUE_METRICS_UNIT_ASSERT_SVH
`define MMC_QUEUE_METRICS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MMC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("queue metrics assertion failed");
// next-cycle implication
`define MMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("queue metrics assertion failed");
`else
`define MMC_ASSERT_NOW(label, clk, rst, ante, cons)
`define MMC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/mmc_pkg.sv
// ----------------------------------------------------------------------------
// mmc_pkg
// Types, constants and helpers shared by the queue metrics unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mmc_pkg;

   localparam int MAX_SERVERS_DEFAULT = 16;
   localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
   localparam logic [63:0] SAT64   = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_RATE = 2'd1,
      STATUS_UNSTABLE  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SHIFT_0  = 2'd0,
      SHIFT_16 = 2'd1,
      SHIFT_32 = 2'd2
   } shift_type;

   typedef struct packed {
      logic [31:0] arrival_rate;
      logic [31:0] service_rate;
      logic [4:0]  servers;
   } req_type;

   typedef struct packed {
      logic [63:0] idle_probability;
      logic [63:0] mean_in_system;
      logic [63:0] mean_time_in_system;
      logic [63:0] mean_in_queue;
      logic [63:0] mean_wait_in_queue;
      logic [63:0] utilization;
      status_type  status;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] x;
      logic [63:0] y;
      shift_type   shift;
   } div_req_type;

   typedef struct packed {
      logic        start;
      logic [63:0] x;
      logic [63:0] y;
   } mul_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] value;
   } unit_res_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHECK, ST_RATIO, ST_SUM, ST_TERM_MUL, ST_TERM_DIV, ST_TAIL, ST_P0,
      ST_LQ_T, ST_LQ_A, ST_LQ_D1, ST_LQ_D2, ST_W, ST_WQ, ST_UTIL, ST_FINISH
   } state_type;

   // saturating 64-bit add
   function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y);
      logic [64:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[64] ? SAT64 : s[63:0];
   endfunction

endpackage

### rtl/mmc_div.sv
// ----------------------------------------------------------------------------
// mmc_div
// Radix-2 restoring divider: floor(x * 2^s / y), s of 0, 16 or 32, saturating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mmc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  mmc_pkg::div_req_type req,
   output mmc_pkg::unit_res_type res
);
   import mmc_pkg::*;

   logic        busy_ff, busy_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] lo_ff, lo_in;
   logic [63:0] y_ff, y_in;
   logic [63:0] q_ff, q_in;
   logic [63:0] hi_w, lo_w;
   logic [64:0] rem_w;
   logic        ge_w;

   // split of the shifted dividend
   always_comb begin
      case (req.shift)
         SHIFT_16: begin
            hi_w = {48'b0, req.x[63:48]};
            lo_w = {req.x[47:0], 16'b0};
         end
         SHIFT_32: begin
            hi_w = {32'b0, req.x[63:32]};
            lo_w = {req.x[31:0], 32'b0};
         end
         default: begin
            hi_w = '0;
            lo_w = req.x;
         end
      endcase
   end

   // one quotient bit per cycle
   always_comb begin
      rem_w   = {rem_ff, lo_ff[63]};
      ge_w    = rem_w >= {1'b0, y_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      y_in    = y_ff;
      q_in    = q_ff;
      if (req.start) begin
         busy_in = 1'b1;
         y_in    = req.y;
         rem_in  = hi_w;
         lo_in   = lo_w;
         q_in    = '0;
         if (req.y == '0 || hi_w >= req.y) begin
            q_in   = SAT64;
            cnt_in = '0;
         end else begin
            cnt_in = 7'd64;
         end
      end else if (busy_ff && cnt_ff != '0) begin
         rem_in = ge_w ? 64'(rem_w - {1'b0, y_ff}) : rem_w[63:0];
         lo_in  = {lo_ff[62:0], 1'b0};
         q_in   = {q_ff[62:0], ge_w};
         cnt_in = cnt_ff - 7'd1;
      end else if (busy_ff) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      y_ff   <= y_in;
      q_ff   <= q_in;
   end

   assign res.busy  = busy_ff;
   assign res.done  = busy_ff && cnt_ff == '0;
   assign res.value = q_ff;
endmodule

### rtl/mmc_mul.sv
// ----------------------------------------------------------------------------
// mmc_mul
// Q32.32 multiplier: floor(x*y / 2^32), saturating, one 32x32 product a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mmc_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  mmc_pkg::mul_req_type req,
   output mmc_pkg::unit_res_type res
);
   import mmc_pkg::*;

   logic        busy_ff, busy_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] y_ff, y_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] opa_w, opb_w;

   // partial product order: hh, hl, lh, ll
   always_comb begin
      case (cnt_ff)
         3'd0:    begin opa_w = x_ff[63:32]; opb_w = y_ff[63:32]; end
         3'd1:    begin opa_w = x_ff[63:32]; opb_w = y_ff[31:0];  end
         3'd2:    begin opa_w = x_ff[31:0];  opb_w = y_ff[63:32]; end
         default: begin opa_w = x_ff[31:0];  opb_w = y_ff[31:0];  end
      endcase
   end

   // multiply, then accumulate the previous product
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = req.x;
         y_in    = req.y;
         acc_in  = '0;
      end else if (busy_ff && cnt_ff != 3'd5) begin
         prod_in = {32'b0, opa_w} * {32'b0, opb_w};
         case (cnt_ff) inside
            3'd1:       acc_in = (prod_ff[63:32] != '0) ? SAT64 : {prod_ff[31:0], 32'b0};
            3'd2, 3'd3: acc_in = sat_add(acc_ff, prod_ff);
            3'd4:       acc_in = sat_add(acc_ff, {32'b0, prod_ff[63:32]});
            default:    acc_in = acc_ff;
         endcase
         cnt_in = cnt_ff + 3'd1;
      end else if (busy_ff) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign res.busy  = busy_ff;
   assign res.done  = busy_ff && cnt_ff == 3'd5;
   assign res.value = acc_ff;
endmodule

### rtl/mmc_queue_metrics_unit.sv
// ----------------------------------------------------------------------------
// mmc_queue_metrics_unit
// Steady-state M/M/c queue metrics from arrival rate, service rate and servers.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries lambda, mu (Q16.16) and the server count c; rsp
//   channel returns P0, L, W, Lq, Wq, utilization (Q32.32) and a status code.
//   One item is in work at a time; req_ready is high only while idle.
//   A sequencer runs every division through one shared 64-bit divider (a
//   saturating division skips the quotient steps) and every Q32.32 product
//   through one Q32.32 multiplier. The next transfer can be accepted in the
//   same cycle that rsp_valid rises. A zero rate or unstable queue is
//   answered from the check state through the finish state, with zero metrics.
//   The result waits in an output register; when rsp_ready is low the next
//   item may already be accepted and computed, and its result then holds in
//   the sequencer until the output register frees.
//   Reset (synchronous) returns to idle and drops any pending result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mmc_queue_metrics_unit_assert.svh"
module mmc_queue_metrics_unit #(
   parameter int MAX_SERVERS = mmc_pkg::MAX_SERVERS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mmc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mmc_pkg::rsp_type rsp_data
);
   import mmc_pkg::*;

   localparam int CW = $clog2(MAX_SERVERS + 1);

   state_type       state_ff, state_in;
   logic            issued_ff, issued_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;
   status_type      status_ff, status_in;
   logic [31:0]     lam_ff, lam_in;
   logic [31:0]     mu_ff, mu_in;
   logic [CW-1:0]   c_ff, c_in;
   logic [CW-1:0]   i_ff, i_in;
   logic [31+CW:0]  cmu_ff, cmu_in;
   logic [63:0]     a_ff, a_in;
   logic [63:0]     t_ff, t_in;
   logic [63:0]     sum_ff, sum_in;
   logic [63:0]     tail_ff, tail_in;
   logic [63:0]     p0_ff, p0_in;
   logic [63:0]     lq_ff, lq_in;
   logic [63:0]     w_ff, w_in;
   logic [63:0]     wq_ff, wq_in;
   logic [63:0]     util_ff, util_in;
   logic [CW-1:0]   i_plus_w;
   logic [63:0]     d_w, l_w;
   div_req_type     div_req;
   mul_req_type     mul_req;
   unit_res_type    div_res, mul_res;

   // saturating product with a server count
   function automatic logic [63:0] sat_mul_small(input logic [63:0] x,
                                                 input logic [CW-1:0] k);
      logic [63+CW:0] p;
      p = (64 + CW)'(x) * (64 + CW)'(k);
      return (p[63+CW:64] != '0) ? SAT64 : p[63:0];
   endfunction

   mmc_div u_div (.clock(clock), .reset(reset), .req(div_req), .res(div_res));
   mmc_mul u_mul (.clock(clock), .reset(reset), .req(mul_req), .res(mul_res));

   assign i_plus_w = i_ff + CW'(1);
   assign d_w      = {32'(c_ff), 32'b0} - a_ff;
   assign l_w      = sat_add(lq_ff, a_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      status_in    = status_ff;
      lam_in       = lam_ff;
      mu_in        = mu_ff;
      c_in         = c_ff;
      i_in         = i_ff;
      cmu_in       = cmu_ff;
      a_in         = a_ff;
      t_in         = t_ff;
      sum_in       = sum_ff;
      tail_in      = tail_ff;
      p0_in        = p0_ff;
      lq_in        = lq_ff;
      w_in         = w_ff;
      wq_in        = wq_ff;
      util_in      = util_ff;
      div_req      = '{start: 1'b0, x: '0, y: '0, shift: SHIFT_0};
      mul_req      = '{start: 1'b0, x: '0, y: '0};

      // output transfer frees the register
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_valid) begin
               lam_in = req_data.arrival_rate;
               mu_in  = req_data.service_rate;
               if (req_data.servers == '0) begin
                  c_in = CW'(1);
               end else if (32'(req_data.servers) > MAX_SERVERS) begin
                  c_in = CW'(MAX_SERVERS);
               end else begin
                  c_in = CW'(req_data.servers);
               end
               i_in     = '0;
               sum_in   = '0;
               t_in     = ONE_Q32;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmu_in = (32 + CW)'(mu_ff) * (32 + CW)'(c_ff);
            if (lam_ff == '0 || mu_ff == '0) begin
               status_in = STATUS_ZERO_RATE;
               state_in  = ST_FINISH;
            end else if ((32 + CW)'(lam_ff) >= cmu_in) begin
               status_in = STATUS_UNSTABLE;
               state_in  = ST_FINISH;
            end else begin
               status_in = STATUS_OK;
               state_in  = ST_RATIO;
            end
         end
         ST_RATIO: begin
            div_req   = '{start: !issued_ff, x: 64'(lam_ff), y: 64'(mu_ff), shift: SHIFT_32};
            issued_in = 1'b1;
            if (div_res.done) begin
               issued_in = 1'b0;
               a_in      = div_res.value;
               state_in  = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_in   = sat_add(sum_ff, t_ff);
            state_in = ST_TERM_MUL;
         end
         ST_TERM_MUL: begin
            mul_req   = '{start: !issued_ff, x: t_ff, y: a_ff};
            issued_in = 1'b1;
            if (mul_res.done) begin
               issued_in = 1'b0;
               t_in      = mul_res.value;
               state_in  = ST_TERM_DIV;
            end
         end
         ST_TERM_DIV: begin
            div_req   = '{start: !issued_ff, x: t_ff, y: 64'(i_plus_w), shift: SHIFT_0};
            issued_in = 1'b1;
            if (div_res.done) begin
               issued_in = 1'b0;
               t_in      = div_res.value;
               i_in      = i_plus_w;
               state_in  = (i_plus_w == c_ff) ? ST_TAIL : ST_SUM;
            end
         end
         ST_TAIL: begin
            div_req   = '{start: !issued_ff, x: sat_mul_small(t_ff, c_ff), y: d_w,
                          shift: SHIFT_32};
            issued_in = 1'b1;
            if (div_res.done) begin
               issued_in = 1'b0;
               tail_in   = div_res.value;
               state_in  = ST_P0;
            end
         end
         ST_P0: begin
            div_req   = '{start: !issued_ff, x: ONE_Q32, y: sat_add(sum_ff, tail_ff),
                          shift: SHIFT_32};
            issued_in = 1'b1;
            if (div_res.done) begin
               issued_in = 1'b0;
               p0_in     = div_res.value;
               state_in  = ST_LQ_T;
            end
         end
         ST_LQ_T: begin
            mul_req   = '{start: !issued_ff, x: t_ff, y: p0_ff};
            issued_in = 1'b1;
            if (mul_res.done) begin
               issued_in = 1'b0;
               lq_in     = sat_mul_small(mul_res.value, c_ff);
               state_in  = ST_LQ_A;
            end
         end
         ST_LQ_A: begin
            mul_req   = '{start: !issued_ff, x: lq_ff, y: a_ff};
            issued_in = 1'b1;
            if (mul_res.done) begin
               issued_in = 1'b0;
               lq_in     = mul_res.value;
               state_in  = ST_LQ_D1;
            end
         end
         ST_LQ_D1, ST_LQ_D2: begin
            div_req   = '{start: !issued_ff, x: lq_ff, y: d_w, shift: SHIFT_32};
            issued_in = 1'b1;
            if (div_res.done) begin
               issued_in = 1'b0;
               lq_in     = div_res.value;
               state_in  = (state_ff == ST_LQ_D1) ? ST_LQ_D2 : ST_W;
            end
         end
         ST_W: begin
            div_req   = '{start: !issued_ff, x: l_w, y: 64'(lam_ff), shift: SHIFT_16};
            issued_in = 1'b1;
            if (div_res.done) begin
               issued_in = 1'b0;
               w_in      = div_res.value;
               state_in  = ST_WQ;
            end
         end
         ST_WQ: begin
            div_req   = '{start: !issued_ff, x: lq_ff, y: 64'(lam_ff), shift: SHIFT_16};
            issued_in = 1'b1;
            if (div_res.done) begin
               issued_in = 1'b0;
               wq_in     = div_res.value;
               state_in  = ST_UTIL;
            end
         end
         ST_UTIL: begin
            div_req   = '{start: !issued_ff, x: 64'(lam_ff), y: 64'(cmu_ff), shift: SHIFT_32};
            issued_in = 1'b1;
            if (div_res.done) begin
               issued_in = 1'b0;
               util_in   = div_res.value;
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in.status = status_ff;
               if (status_ff == STATUS_OK) begin
                  rsp_data_in.idle_probability    = p0_ff;
                  rsp_data_in.mean_in_system      = l_w;
                  rsp_data_in.mean_time_in_system = w_ff;
                  rsp_data_in.mean_in_queue       = lq_ff;
                  rsp_data_in.mean_wait_in_queue  = wq_ff;
                  rsp_data_in.utilization         = util_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      status_ff   <= status_in;
      lam_ff      <= lam_in;
      mu_ff       <= mu_in;
      c_ff        <= c_in;
      i_ff        <= i_in;
      cmu_ff      <= cmu_in;
      a_ff        <= a_in;
      t_ff        <= t_in;
      sum_ff      <= sum_in;
      tail_ff     <= tail_in;
      p0_ff       <= p0_in;
      lq_ff       <= lq_in;
      w_ff        <= w_in;
      wq_ff       <= wq_in;
      util_ff     <= util_in;
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `MMC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `MMC_ASSERT_NOW(a_flag_zero, clock, reset, rsp_valid && rsp_data.status != STATUS_OK, rsp_data.utilization == '0 && rsp_data.idle_probability == '0)
   `MMC_ASSERT_NOW(a_one_unit, clock, reset, 1'b1, !(div_res.busy && mul_res.busy))
   `MMC_ASSERT_NOW(a_util_below_one, clock, reset, rsp_valid && rsp_data.status == STATUS_OK, rsp_data.utilization < ONE_Q32)
endmodule

### tb/tb_mmc_queue_metrics_unit.sv
// ----------------------------------------------------------------------------
// tb_mmc_queue_metrics_unit
// Self-checking bench for the M/M/c queue metrics unit: directed table of
// corner cases, then random queries of mostly stable queues, each result
// compared field by field with a fixed-point predictor of the metrics.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_mmc_queue_metrics_unit;
   import mmc_pkg::*;

   localparam int N_RANDOM  = 500;
   localparam int WATCHDOG  = 50000;
   localparam int N_DIRECT  = 12;
   localparam logic [63:0] MAXV = 64'hFFFF_FFFF_FFFF_FFFF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type metrics_expected[$];
   int      error_count = 0;
   int      idle_cycles = 0;
   bit      stim_done = 1'b0;
   bit      hold_off = 1'b0;

   mmc_queue_metrics_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // saturating fixed-point helpers
   function automatic logic [63:0] q_add(logic [63:0] x, logic [63:0] y);
      logic [64:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[64] ? MAXV : s[63:0];
   endfunction

   function automatic logic [63:0] q_scale(logic [63:0] x, logic [63:0] k);
      logic [127:0] p;
      p = {64'd0, x} * {64'd0, k};
      return (p[127:64] != 0) ? MAXV : p[63:0];
   endfunction

   function automatic logic [63:0] q_mul(logic [63:0] x, logic [63:0] y);
      logic [127:0] p;
      p = {64'd0, x} * {64'd0, y};
      return (p[127:96] != 0) ? MAXV : p[95:32];
   endfunction

   function automatic logic [63:0] q_div(logic [63:0] x, logic [63:0] y, int s);
      logic [127:0] n, q;
      if (y == 0) return MAXV;
      n = {64'd0, x} << s;
      q = n / {64'd0, y};
      return (q[127:64] != 0) ? MAXV : q[63:0];
   endfunction

   // expected metrics for one query
   function automatic rsp_type queue_metrics(req_type r);
      rsp_type o;
      logic [63:0] lam, mu, c, cmu, a, t, sum, d, tail, p0, lq, l;
      o = '0;
      lam = {32'd0, r.arrival_rate};
      mu = {32'd0, r.service_rate};
      c = {59'd0, r.servers};
      if (c == 0) c = 64'd1;
      if (c > 64'(MAX_SERVERS_DEFAULT)) c = 64'(MAX_SERVERS_DEFAULT);
      cmu = mu * c;
      if (lam == 0 || mu == 0) begin
         o.status = STATUS_ZERO_RATE;
         return o;
      end
      if (lam >= cmu) begin
         o.status = STATUS_UNSTABLE;
         return o;
      end
      a = q_div(lam, mu, 32);
      t = ONE_Q32;
      sum = '0;
      for (int i = 0; i < c; i++) begin
         sum = q_add(sum, t);
         t = q_mul(t, a) / 64'(i + 1);
      end
      d = (c << 32) - a;
      tail = q_div(q_scale(t, c), d, 32);
      p0 = q_div(ONE_Q32, q_add(sum, tail), 32);
      lq = q_div(q_div(q_mul(q_scale(q_mul(t, p0), c), a), d, 32), d, 32);
      l = q_add(lq, a);
      o.idle_probability = p0;
      o.mean_in_system = l;
      o.mean_time_in_system = q_div(l, lam, 16);
      o.mean_in_queue = lq;
      o.mean_wait_in_queue = q_div(lq, lam, 16);
      o.utilization = q_div(lam, cmu, 32);
      o.status = STATUS_OK;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // directed table; typed expectation only where obvious
   typedef struct {
      req_type     item;
      bit          typed;
      status_type  status;
   } dir_row_type;
   dir_row_type dir_table[N_DIRECT];

   initial begin
      dir_table[0]  = '{'{32'd0, 32'h0001_0000, 5'd1}, 1, STATUS_ZERO_RATE};
      dir_table[1]  = '{'{32'h0001_0000, 32'd0, 5'd4}, 1, STATUS_ZERO_RATE};
      dir_table[2]  = '{'{32'd0, 32'd0, 5'd0}, 1, STATUS_ZERO_RATE};
      dir_table[3]  = '{'{32'h0001_0000, 32'h0001_0000, 5'd1}, 1, STATUS_UNSTABLE};
      dir_table[4]  = '{'{32'hFFFF_FFFF, 32'd1, 5'd31}, 1, STATUS_UNSTABLE};
      dir_table[5]  = '{'{32'h0000_8000, 32'h0001_0000, 5'd1}, 0, STATUS_OK};
      dir_table[6]  = '{'{32'h0000_8000, 32'h0001_0000, 5'd0}, 0, STATUS_OK};
      dir_table[7]  = '{'{32'h000F_FFFF, 32'h0001_0000, 5'd16}, 0, STATUS_OK};
      dir_table[8]  = '{'{32'h000F_FFFF, 32'h0001_0000, 5'd31}, 0, STATUS_OK};
      dir_table[9]  = '{'{32'hFFFF_FFFE, 32'hFFFF_FFFF, 5'd1}, 0, STATUS_OK};
      dir_table[10] = '{'{32'd1, 32'hFFFF_FFFF, 5'd16}, 0, STATUS_OK};
      dir_table[11] = '{'{32'hFFFF_FFFF, 32'h1000_0000, 5'd17}, 0, STATUS_OK};
   end

   // one request transfer; valid stays up for the next item of a burst
   task automatic send_query(req_type r, bit typed, status_type st);
      rsp_type e;
      e = queue_metrics(r);
      if (typed) begin
         e = '0;
         e.status = st;
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      metrics_expected.push_back(e);
   endtask

   function automatic req_type random_query();
      req_type r;
      int m;
      m = $urandom_range(0, 9);
      r.servers = 5'($urandom_range(0, 31));
      if (m < 7) r.servers = 5'($urandom_range(1, 4));
      r.service_rate = $urandom;
      if (m < 8) r.service_rate = $urandom_range(32'h0000_1000, 32'h0010_0000);
      if (m < 7) r.arrival_rate = r.service_rate * (r.servers == 0 ? 1 : r.servers)
         / 32'd1000 * $urandom_range(1, 999);
      else r.arrival_rate = $urandom;
      if (m == 9) r.arrival_rate = $urandom & 32'h0000_00FF;
      return r;
   endfunction

   // sender with bursts and gaps
   initial begin
      int burst;
      int gap;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int k = 0; k < N_DIRECT; k++)
         send_query(dir_table[k].item, dir_table[k].typed, dir_table[k].status);
      for (int k = 0; k < N_RANDOM; ) begin
         burst = $urandom_range(1, 8);
         gap = $urandom_range(0, 3) * $urandom_range(0, 1);
         for (int b = 0; b < burst; b++, k++)
            send_query(random_query(), 0, STATUS_OK);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int phase;
      phase = 0;
      forever begin
         @(posedge clock);
         phase++;
         if (phase == 40) hold_off = 1'b1;
         if (phase == 40 + 9000) hold_off = 1'b0;
         if (hold_off) rsp_ready <= 1'b0;
         else if ((phase / 500) % 2 == 0) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // result check
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (metrics_expected.size() == 0) begin
            report_mismatch("unexpected transfer", {62'd0, rsp_data.status}, '0);
         end else begin
            e = metrics_expected.pop_front();
            if (rsp_data.idle_probability !== e.idle_probability)
               report_mismatch("p0", rsp_data.idle_probability, e.idle_probability);
            if (rsp_data.mean_in_system !== e.mean_in_system)
               report_mismatch("L", rsp_data.mean_in_system, e.mean_in_system);
            if (rsp_data.mean_time_in_system !== e.mean_time_in_system)
               report_mismatch("W", rsp_data.mean_time_in_system, e.mean_time_in_system);
            if (rsp_data.mean_in_queue !== e.mean_in_queue)
               report_mismatch("Lq", rsp_data.mean_in_queue, e.mean_in_queue);
            if (rsp_data.mean_wait_in_queue !== e.mean_wait_in_queue)
               report_mismatch("Wq", rsp_data.mean_wait_in_queue, e.mean_wait_in_queue);
            if (rsp_data.utilization !== e.utilization)
               report_mismatch("util", rsp_data.utilization, e.utilization);
            if (rsp_data.status !== e.status)
               report_mismatch("status", {62'd0, rsp_data.status}, {62'd0, e.status});
         end
      end
   end

   // watchdog and end of run
   initial begin
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("watchdog timeout");
            $display("CHECKS FAILED");
            $finish;
         end
         if (stim_done && metrics_expected.size() == 0) begin
            repeat (2000) @(posedge clock);
            if (error_count == 0 && metrics_expected.size() == 0) begin
               $display("ALL CHECKS PASSED");
            end else begin
               $display("CHECKS FAILED");
            end
            $finish;
         end
      end
   end

endmodule
